// ===== hdl/c32dfr_pkg.sv =====
// Package for the CRC-32 frame deframer: byte roles, frame status codes,
// frame layout and CRC-32 constants. No dependencies.
package c32dfr_pkg;

    // Frame layout
    localparam int unsigned POS_W     = 17;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned TYPE_W    = 16;
    localparam int unsigned CRC_W     = 32;
    localparam logic [POS_W-1:0] HDR_BYTES = 17'd4;

    // Reflected IEEE 802.3 CRC-32
    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT      = 32'hFFFF_FFFF;

    // Role of each passed-through byte
    typedef enum logic [1:0] {
        ROLE_HEADER  = 2'd0,
        ROLE_PAYLOAD = 2'd1,
        ROLE_TRAILER = 2'd2
    } byte_role_t;

    // Frame result reported on the last trailer byte
    typedef enum logic [1:0] {
        STAT_OPEN     = 2'd0,
        STAT_CRC_OK   = 2'd1,
        STAT_CRC_BAD  = 2'd2
    } frame_status_t;

    // Position of a header byte within the header
    typedef enum logic [1:0] {
        HDR_TYPE_HI = 2'd0,
        HDR_TYPE_LO = 2'd1,
        HDR_LEN_HI  = 2'd2,
        HDR_LEN_LO  = 2'd3
    } hdr_slot_t;

endpackage

// ===== hdl/crc32_frame_deframer_core.sv =====
// Top level of the CRC-32 frame deframer: frame state, CRC check, result register.
// Depends on c32dfr_pkg, c32dfr_in_reg and c32dfr_crc_byte.
//
//   channel | direction | ports                                        | handshake
//   input   | in        | s_rx_byte                                    | s_valid / s_ready
//   result  | out       | m_out_byte, m_byte_role, m_frame_type,       | m_valid / m_ready
//           |           | m_last_of_frame, m_frame_status              |
//
// Each byte goes through the input register, then through the CRC byte update and
// frame decode into the result register. One byte per cycle is sustained unless
// m_ready stalls the result; the single byte-wise CRC update sets the path.
// Reset (synchronous, active low aresetn) empties both registers and starts a new frame.
// A stalled result holds the frame state; the input register still takes one byte.
module crc32_frame_deframer_core
    import c32dfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic [1:0]        m_byte_role,
    output logic [TYPE_W-1:0] m_frame_type,
    output logic              m_last_of_frame,
    output logic [1:0]        m_frame_status
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       advance;

    // Frame state
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [LEN_W-1:0]  len_reg,  len_next;
    logic [CRC_W-1:0]  crc_reg,  crc_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic              miss_reg, miss_next;

    // Result register
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          byte_reg;
    byte_role_t          role_reg, role_next;
    logic [TYPE_W-1:0]   ftype_reg, ftype_next;
    logic                last_reg, last_next;
    frame_status_t       stat_reg, stat_next;

    logic [CRC_W-1:0] crc_upd;
    logic [POS_W-1:0] body_end;
    logic [POS_W-1:0] trl_off;
    logic [CRC_W-1:0] crc_inv;
    logic [7:0]       expect_byte;

    c32dfr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_rx_byte),
        .take       (advance),
        .hold_valid (in_valid),
        .hold_data  (in_byte)
    );

    c32dfr_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (in_byte),
        .crc_out (crc_upd)
    );

    // Byte moves to the result register when that is empty or being drained
    assign advance = in_valid && (!m_valid_reg || m_ready);

    assign body_end = HDR_BYTES + {1'b0, len_reg};
    assign trl_off  = pos_reg - body_end;
    assign crc_inv  = ~crc_reg;

    // Expected trailer byte, least significant first
    always_comb begin
        case (trl_off[1:0])
            2'd0:    expect_byte = crc_inv[7:0];
            2'd1:    expect_byte = crc_inv[15:8];
            2'd2:    expect_byte = crc_inv[23:16];
            default: expect_byte = crc_inv[31:24];
        endcase
    end

    // Frame decode and next state
    always_comb begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        type_next  = type_reg;
        miss_next  = miss_reg;
        role_next  = ROLE_HEADER;
        ftype_next = '0;
        last_next  = 1'b0;
        stat_next  = STAT_OPEN;

        if (pos_reg < HDR_BYTES) begin
            role_next = ROLE_HEADER;
            case (hdr_slot_t'(pos_reg[1:0]))
                HDR_TYPE_HI: type_next = {in_byte, type_reg[7:0]};
                HDR_TYPE_LO: type_next = {type_reg[15:8], in_byte};
                HDR_LEN_HI:  len_next  = {in_byte, len_reg[7:0]};
                HDR_LEN_LO:  len_next  = {len_reg[15:8], in_byte};
                default:     len_next  = len_reg;
            endcase
            crc_next = crc_upd;
            pos_next = pos_reg + 1'b1;
        end else if (pos_reg < body_end) begin
            role_next = ROLE_PAYLOAD;
            crc_next  = crc_upd;
            pos_next  = pos_reg + 1'b1;
        end else begin
            role_next = ROLE_TRAILER;
            if (expect_byte != in_byte) begin
                miss_next = 1'b1;
            end
            if (trl_off[1:0] == 2'd3) begin
                // Last trailer byte: report and start a new frame
                last_next  = 1'b1;
                ftype_next = type_reg;
                stat_next  = miss_next ? STAT_CRC_BAD : STAT_CRC_OK;
                pos_next   = '0;
                len_next   = '0;
                crc_next   = CRC_INIT;
                type_next  = '0;
                miss_next  = 1'b0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Result valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            len_reg     <= '0;
            crc_reg     <= CRC_INIT;
            type_reg    <= '0;
            miss_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                pos_reg  <= pos_next;
                len_reg  <= len_next;
                crc_reg  <= crc_next;
                type_reg <= type_next;
                miss_reg <= miss_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg  <= in_byte;
            role_reg  <= role_next;
            ftype_reg <= ftype_next;
            last_reg  <= last_next;
            stat_reg  <= stat_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = byte_reg;
    assign m_byte_role     = role_reg;
    assign m_frame_type    = ftype_reg;
    assign m_last_of_frame = last_reg;
    assign m_frame_status  = stat_reg;

endmodule

// ===== hdl/c32dfr_in_reg.sv =====
// Input register stage of the CRC-32 frame deframer.
// Holds one received byte; depends on nothing but the handshake.
module c32dfr_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data,
    input  logic       take,
    output logic       hold_valid,
    output logic [7:0] hold_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Free when empty, or when the held byte moves on this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

// ===== hdl/c32dfr_crc_byte.sv =====
// Byte-wise update of the reflected CRC-32 (eight shift/xor steps).
// Depends on c32dfr_pkg for the polynomial.
module c32dfr_crc_byte
    import c32dfr_pkg::*;
(
    input  logic [CRC_W-1:0] crc_in,
    input  logic [7:0]       data,
    output logic [CRC_W-1:0] crc_out
);

    // One bit per step, LSB first
    always_comb begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

// ===== test/crc32_frame_deframer_core_tb.sv =====
// Self-checking testbench for crc32_frame_deframer_core: streams framed bytes with random
// gaps and back-pressure, predicts every output transaction and compares field by field.
// Depends on c32dfr_pkg and the deframer RTL only.
module crc32_frame_deframer_core_tb;
    import c32dfr_pkg::*;

    localparam logic [1:0] TRL_LAST   = 2'd3;   // index of the final trailer byte
    localparam int         RAND_ITEMS = 1150;

    typedef enum int {
        FLAW_NONE,
        FLAW_TRAILER,   // one trailer bit flipped
        FLAW_LEN,       // length field altered after the CRC was taken
        FLAW_BODY,      // type or payload byte altered after the CRC was taken
        FLAW_NOISE      // trailer replaced by random bits
    } flaw_t;

    typedef struct {
        logic [7:0]        data;
        byte_role_t        role;
        logic [TYPE_W-1:0] ftype;
        logic              last;
        frame_status_t     status;
    } deframed_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [7:0]        s_rx_byte = 8'h00;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [7:0]        m_out_byte;
    logic [1:0]        m_byte_role;
    logic [TYPE_W-1:0] m_frame_type;
    logic              m_last_of_frame;
    logic [1:0]        m_frame_status;

    logic [7:0]  rx_stream_q[$];    // bytes waiting to be offered
    deframed_t   deframed_q[$];     // predicted output transactions, oldest first

    // Predictor frame state
    logic [POS_W-1:0]  fr_pos;
    logic [LEN_W-1:0]  fr_len;
    logic [CRC_W-1:0]  fr_crc;
    logic [TYPE_W-1:0] fr_type;
    logic              fr_bad;

    int err_count    = 0;
    int results_seen = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int src_run      = 0;
    int rdy_run      = 0;

    crc32_frame_deframer_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_role     (m_byte_role),
        .m_frame_type    (m_frame_type),
        .m_last_of_frame (m_last_of_frame),
        .m_frame_status  (m_frame_status)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Reflected CRC-32, one byte
    function automatic logic [CRC_W-1:0] crc32_step(input logic [CRC_W-1:0] c,
                                                    input logic [7:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long, with idle-free runs
    function automatic int draw_idle(inout int run_left);
        int r;
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            run_left = $urandom_range(30, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic restart_frame();
        fr_pos  = '0;
        fr_len  = '0;
        fr_crc  = CRC_INIT;
        fr_type = '0;
        fr_bad  = 1'b0;
    endtask

    // Work out the output transaction for one accepted byte
    task automatic deframe_byte(input logic [7:0] b);
        deframed_t        r;
        logic [POS_W-1:0] body_end;
        logic [1:0]       k;
        logic [CRC_W-1:0] fcs;
        body_end = HDR_BYTES + POS_W'(fr_len);
        r.data   = b;
        r.ftype  = '0;
        r.last   = 1'b0;
        r.status = STAT_OPEN;
        if (fr_pos < HDR_BYTES) begin
            r.role = ROLE_HEADER;
            case (hdr_slot_t'(fr_pos[1:0]))
                HDR_TYPE_HI: fr_type[15:8] = b;
                HDR_TYPE_LO: fr_type[7:0]  = b;
                HDR_LEN_HI:  fr_len[15:8]  = b;
                HDR_LEN_LO:  fr_len[7:0]   = b;
                default: ;
            endcase
            fr_crc = crc32_step(fr_crc, b);
            fr_pos = fr_pos + 1'b1;
        end else if (fr_pos < body_end) begin
            r.role = ROLE_PAYLOAD;
            fr_crc = crc32_step(fr_crc, b);
            fr_pos = fr_pos + 1'b1;
        end else begin
            // trailer is compared, not folded into the CRC
            r.role = ROLE_TRAILER;
            k      = 2'(fr_pos - body_end);
            fcs    = ~fr_crc;
            if (fcs[8*k +: 8] != b)
                fr_bad = 1'b1;
            if (k == TRL_LAST) begin
                r.last   = 1'b1;
                r.ftype  = fr_type;
                r.status = fr_bad ? STAT_CRC_BAD : STAT_CRC_OK;
                restart_frame();
            end else begin
                fr_pos = fr_pos + 1'b1;
            end
        end
        deframed_q.push_back(r);
    endtask

    // Build one frame, optionally damaged, and queue its bytes
    task automatic queue_frame(input logic [15:0] ftype, input int len, input flaw_t flaw,
                               input bit extreme);
        logic [7:0]       frm[$];
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] fcs;
        logic [15:0]      len16;
        logic [15:0]      sent_len;
        int               idx;
        len16    = 16'(len);
        sent_len = len16;
        if (flaw == FLAW_LEN)
            sent_len = len16 ^ (16'd1 << $urandom_range(0, 3));
        frm = {ftype[15:8], ftype[7:0], len16[15:8], len16[7:0]};
        for (int i = 0; i < sent_len; i++)
            frm.push_back(extreme ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255)));
        crc = CRC_INIT;
        foreach (frm[i])
            crc = crc32_step(crc, frm[i]);
        fcs = ~crc;
        case (flaw)
            FLAW_LEN: begin
                // boundary follows the altered length; payload count matches it
                frm[3] = sent_len[7:0];
            end
            FLAW_BODY: begin
                // skip the length bytes so the frame boundary stays put
                idx = $urandom_range(0, frm.size() - 3);
                if (idx >= 2)
                    idx += 2;
                frm[idx] ^= 8'($urandom_range(1, 255));
            end
            FLAW_TRAILER: fcs ^= 32'd1 << $urandom_range(0, 31);
            FLAW_NOISE:   fcs = $urandom();
            default: ;
        endcase
        for (int i = 0; i < 4; i++)
            frm.push_back(fcs[8*i +: 8]);
        foreach (frm[i])
            rx_stream_q.push_back(frm[i]);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Driver: offers queued bytes, predicts each accepted transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            restart_frame();
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                deframe_byte(s_rx_byte);
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (rx_stream_q.size() > 0) begin
                s_valid   <= 1'b1;
                s_rx_byte <= rx_stream_q.pop_front();
                gap_left = draw_idle(src_run);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each output transaction, throttles m_ready
    always @(posedge aclk) begin
        deframed_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (deframed_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected output, expected none, actual byte %0h",
                             $time, m_out_byte);
                end else begin
                    want = deframed_q.pop_front();
                    check_field("out_byte",      32'(want.data),   32'(m_out_byte));
                    check_field("byte_role",     32'(want.role),   32'(m_byte_role));
                    check_field("frame_type",    32'(want.ftype),  32'(m_frame_type));
                    check_field("last_of_frame", 32'(want.last),   32'(m_last_of_frame));
                    check_field("frame_status",  32'(want.status), 32'(m_frame_status));
                end
                // long hold-off so the block backs up into its input
                if (results_seen == 300 || results_seen == 800)
                    stall_left = 150;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = draw_idle(rdy_run);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int    pick;
        flaw_t flaw;
        // directed: extreme types, zero length good and bad, extreme payload bytes
        queue_frame(16'hFFFF, 0, FLAW_NONE,    1'b0);
        queue_frame(16'h0000, 0, FLAW_TRAILER, 1'b0);
        queue_frame(16'h8000, 2, FLAW_NONE,    1'b1);

        // random frames, mostly well formed
        while (rx_stream_q.size() < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      flaw = FLAW_NONE;
            else if (pick < 80) flaw = FLAW_TRAILER;
            else if (pick < 86) flaw = FLAW_LEN;
            else if (pick < 93) flaw = FLAW_BODY;
            else                flaw = FLAW_NOISE;
            queue_frame(16'($urandom_range(0, 65535)),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(0, 12),
                        flaw, 1'b0);
        end

        // a short frame to close the stream
        queue_frame(16'($urandom_range(0, 65535)), 3, FLAW_NONE, 1'b0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (rx_stream_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (deframed_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #150_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
